[rtl/core/fmrc_pkg.sv]
// ----------------------------------------------------------------------------
// fmrc_pkg
// Types and fixed constants shared by the first-match rule classifier:
// rule word layouts, item command record, queue status and sequencer states.
// ----------------------------------------------------------------------------
package fmrc_pkg;

	// stored rule word widths
	localparam int SHAPE_W      = 40;
	localparam int TYPE_W       = 36;
	localparam int ARG_W        = 64;
	localparam int COUNT_W      = 5;

	// rule words are zero-extended to this width before set entries are picked,
	// so entries lying past the stored word read as zero
	localparam int SET_EXT_W    = 68;

	// shape word layout
	localparam int REQ_LO       = 0;
	localparam int REQ_W        = 8;
	localparam int STRICT_BIT   = 8;
	localparam int S0_CNT_LO    = 9;
	localparam int SET_CNT_W    = 3;
	localparam int S0_BASE      = 12;
	localparam int S0_EW        = 7;

	// dtype word layout
	localparam int DT_CNT_LO    = 0;
	localparam int HAS_ARG_BIT  = 3;
	localparam int DT_BASE      = 4;
	localparam int DT_EW        = 8;

	// slot number field, sized for the largest table (256 opcodes x 64 rules)
	localparam int SLOT_FIELD_W = 14;

	// queue between front and back
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;
	localparam int QLVL_W       = 2;

	typedef enum logic {
		OP_CLASSIFY = 1'b0,
		OP_WRITE    = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		WSEL_SHAPE = 2'd0,
		WSEL_TYPE  = 2'd1,
		WSEL_ARG   = 2'd2,
		WSEL_COUNT = 2'd3
	} word_sel_e;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_COUNT,
		BK_SCAN,
		BK_RESULT
	} back_state_e;

	// decoded item, one queue entry
	typedef struct packed {
		logic                    is_wr;
		word_sel_e               sel;
		logic                    in_range;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [7:0]              op_idx;
		logic [7:0]              src_count;
		logic [6:0]              src0_op;
		logic [7:0]              dtype_code;
		logic                    arg_int;
		logic [63:0]             data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/core/fmrc_front.sv]
// ----------------------------------------------------------------------------
// fmrc_front
// Input stage: takes an item, decodes write or classify, checks address range,
// computes the table slot and registers the command toward the queue.
// ----------------------------------------------------------------------------
module fmrc_front #(
	parameter int OP_CODES     = 128,
	parameter int RULES_PER_OP = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                op,
	input  logic [6:0]          node_op,
	input  logic [7:0]          src_count,
	input  logic [6:0]          src0_op,
	input  logic [7:0]          dtype_code,
	input  logic                arg_int,
	input  logic signed [63:0]  arg_value,
	input  logic [10:0]         rule_addr,
	input  logic [1:0]          word_sel,
	input  logic [63:0]         word_data,
	input  fmrc_pkg::q_status_t q_stat,
	output logic                q_push,
	output fmrc_pkg::cmd_t      q_cmd
);
	import fmrc_pkg::*;

	localparam int SLOTS = OP_CODES * RULES_PER_OP;

	logic      valid_s1;
	cmd_t      cmd_s1;
	cmd_t      dec;
	logic      is_wr;
	word_sel_e sel;

	// decode
	always_comb begin
		is_wr = (op == OP_WRITE);
		sel   = word_sel_e'(word_sel);
		dec.is_wr = is_wr;
		dec.sel   = sel;
		if (is_wr) begin
			if (sel == WSEL_COUNT) begin
				dec.in_range = (32'(rule_addr) < 32'(OP_CODES));
			end else begin
				dec.in_range = (32'(rule_addr) < 32'(SLOTS));
			end
			dec.slot   = SLOT_FIELD_W'(rule_addr);
			dec.op_idx = rule_addr[7:0];
			dec.data   = word_data;
		end else begin
			dec.in_range = (32'(node_op) < 32'(OP_CODES));
			dec.slot     = SLOT_FIELD_W'(32'(node_op) * 32'(RULES_PER_OP));
			dec.op_idx   = {1'b0, node_op};
			dec.data     = $unsigned(arg_value);
		end
		dec.src_count  = src_count;
		dec.src0_op    = src0_op;
		dec.dtype_code = dtype_code;
		dec.arg_int    = arg_int;
	end

	// stage register holds while the queue is full
	assign item_stall = valid_s1 && q_stat.full;
	assign q_push     = valid_s1 && !q_stat.full;
	assign q_cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			cmd_s1 <= dec;
		end
	end

endmodule

[rtl/core/fmrc_queue.sv]
// ----------------------------------------------------------------------------
// fmrc_queue
// Two-entry command queue between the front stage and the back sequencer.
// ----------------------------------------------------------------------------
module fmrc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fmrc_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output fmrc_pkg::cmd_t      head,
	output fmrc_pkg::q_status_t stat
);
	import fmrc_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (32'(level_q) == QUEUE_DEPTH);
	assign stat.empty = (level_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[rtl/core/fmrc_back.sv]
// ----------------------------------------------------------------------------
// fmrc_back
// Back sequencer: owns the rule memories, applies table writes and scans the
// rules of an opcode one per cycle, then hands the result to the output reg.
// ----------------------------------------------------------------------------
module fmrc_back #(
	parameter int OP_CODES     = 128,
	parameter int RULES_PER_OP = 16,
	parameter int SET_SIZE     = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fmrc_pkg::cmd_t      head,
	input  fmrc_pkg::q_status_t q_stat,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                matched,
	output logic [3:0]          rule_index
);
	import fmrc_pkg::*;

	localparam int SLOTS  = OP_CODES * RULES_PER_OP;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int OP_W   = $clog2(OP_CODES);
	localparam int CNT_W  = $clog2(RULES_PER_OP + 1);

	// rule memories
	logic [SHAPE_W-1:0] shape_mem [SLOTS];
	logic [TYPE_W-1:0]  type_mem  [SLOTS];
	logic [ARG_W-1:0]   arg_mem   [SLOTS];
	logic [COUNT_W-1:0] count_mem [OP_CODES];
	logic [OP_CODES-1:0] cnt_vld_q;

	logic [SHAPE_W-1:0] shape_rd_q;
	logic [TYPE_W-1:0]  type_rd_q;
	logic [ARG_W-1:0]   arg_rd_q;
	logic [COUNT_W-1:0] cnt_rd_q;
	logic               cnt_vld_rd_q;

	back_state_e        state_q;
	back_state_e        state_d;
	cmd_t               cmd_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               res_hit_q;
	logic [CNT_W-1:0]   res_idx_q;
	logic               out_valid_q;
	logic               matched_q;
	logic [3:0]         rule_index_q;

	logic               mem_wr;
	logic [SLOT_W-1:0]  wr_slot;
	logic [OP_W-1:0]    head_op;
	logic [SLOT_W-1:0]  rd_addr;
	logic [COUNT_W-1:0] cnt_raw;
	logic [CNT_W-1:0]   eff_cnt;
	logic               last;
	logic               out_free;
	logic               scan_start;
	logic               scan_step;
	logic               set_res;
	logic               res_hit_d;
	logic               out_load;

	logic [SET_EXT_W-1:0] shape_ext;
	logic [SET_EXT_W-1:0] type_ext;
	logic [SET_CNT_W-1:0] s0_cnt;
	logic [SET_CNT_W-1:0] dt_cnt;
	logic                 s0_hit;
	logic                 dt_hit;
	logic                 cnt_ok;
	logic                 s0_ok;
	logic                 dt_ok;
	logic                 arg_ok;
	logic                 rule_hit;

	assign wr_slot  = head.slot[SLOT_W-1:0];
	assign head_op  = head.op_idx[OP_W-1:0];
	assign mem_wr   = q_pop && head.is_wr && head.in_range;
	assign out_free = !out_valid_q || !result_stall;

	// count saturates to the list length, unwritten counts read as zero
	always_comb begin
		cnt_raw = cnt_vld_rd_q ? cnt_rd_q : '0;
		eff_cnt = CNT_W'((32'(cnt_raw) > 32'(RULES_PER_OP)) ?
			32'(RULES_PER_OP) : 32'(cnt_raw));
	end

	assign last = (CNT_W'(idx_q + 1'b1) == cnt_q);

	// read address: list base when the scan starts, then one slot per cycle
	always_comb begin
		if (state_q == BK_COUNT) begin
			rd_addr = cmd_q.slot[SLOT_W-1:0];
		end else if (state_q == BK_SCAN && !last) begin
			rd_addr = slot_q + 1'b1;
		end else begin
			rd_addr = slot_q;
		end
	end

	// rule memories, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_wr && head.sel == WSEL_SHAPE) begin
			shape_mem[wr_slot] <= head.data[SHAPE_W-1:0];
		end
		shape_rd_q <= shape_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_wr && head.sel == WSEL_TYPE) begin
			type_mem[wr_slot] <= head.data[TYPE_W-1:0];
		end
		type_rd_q <= type_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_wr && head.sel == WSEL_ARG) begin
			arg_mem[wr_slot] <= head.data;
		end
		arg_rd_q <= arg_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_wr && head.sel == WSEL_COUNT) begin
			count_mem[head_op] <= head.data[COUNT_W-1:0];
		end
		cnt_rd_q <= count_mem[head_op];
	end

	// per-opcode count valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			cnt_vld_rd_q <= 1'b0;
		end else begin
			if (mem_wr && head.sel == WSEL_COUNT) begin
				cnt_vld_q[head_op] <= 1'b1;
			end
			cnt_vld_rd_q <= cnt_vld_q[head_op];
		end
	end

	// rule match against the current item
	always_comb begin
		shape_ext = SET_EXT_W'(shape_rd_q);
		type_ext  = SET_EXT_W'(type_rd_q);
		s0_cnt    = shape_rd_q[S0_CNT_LO +: SET_CNT_W];
		dt_cnt    = type_rd_q[DT_CNT_LO +: SET_CNT_W];
		s0_hit    = 1'b0;
		dt_hit    = 1'b0;
		for (int k = 0; k < SET_SIZE; k++) begin
			if (SET_CNT_W'(k) < s0_cnt &&
				shape_ext[S0_BASE + S0_EW * k +: S0_EW] == cmd_q.src0_op) begin
				s0_hit = 1'b1;
			end
			if (SET_CNT_W'(k) < dt_cnt &&
				type_ext[DT_BASE + DT_EW * k +: DT_EW] == cmd_q.dtype_code) begin
				dt_hit = 1'b1;
			end
		end
		if (shape_rd_q[STRICT_BIT]) begin
			cnt_ok = (cmd_q.src_count == shape_rd_q[REQ_LO +: REQ_W]);
		end else begin
			cnt_ok = (cmd_q.src_count >= shape_rd_q[REQ_LO +: REQ_W]);
		end
		s0_ok    = (s0_cnt == '0) || (cmd_q.src_count == '0) || s0_hit;
		dt_ok    = (dt_cnt == '0) || dt_hit;
		arg_ok   = !type_rd_q[HAS_ARG_BIT] ||
			(cmd_q.arg_int && cmd_q.data == arg_rd_q);
		rule_hit = cnt_ok && s0_ok && dt_ok && arg_ok;
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		scan_start = 1'b0;
		scan_step  = 1'b0;
		set_res    = 1'b0;
		res_hit_d  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					q_pop = 1'b1;
					if (head.is_wr) begin
						set_res = 1'b1;
						state_d = BK_RESULT;
					end else begin
						state_d = BK_COUNT;
					end
				end
			end
			BK_COUNT: begin
				if (!cmd_q.in_range || eff_cnt == '0) begin
					set_res = 1'b1;
					state_d = BK_RESULT;
				end else begin
					scan_start = 1'b1;
					state_d    = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (rule_hit) begin
					set_res   = 1'b1;
					res_hit_d = 1'b1;
					state_d   = BK_RESULT;
				end else if (last) begin
					set_res = 1'b1;
					state_d = BK_RESULT;
				end else begin
					scan_step = 1'b1;
				end
			end
			BK_RESULT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (scan_start) begin
			slot_q <= cmd_q.slot[SLOT_W-1:0];
			idx_q  <= '0;
			cnt_q  <= eff_cnt;
		end else if (scan_step) begin
			slot_q <= slot_q + 1'b1;
			idx_q  <= idx_q + 1'b1;
		end
	end

	// command and pending result
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= head;
		end
		if (set_res) begin
			res_hit_q <= res_hit_d;
			res_idx_q <= res_hit_d ? idx_q : '0;
		end
		if (out_load) begin
			matched_q    <= res_hit_q;
			rule_index_q <= 4'(res_idx_q);
		end
	end

	// output register, one transfer per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign matched      = matched_q;
	assign rule_index   = rule_index_q;

endmodule

[rtl/core/first_match_rule_classifier.sv]
// ----------------------------------------------------------------------------
// first_match_rule_classifier
// Rule table classifier: per-opcode ordered rule lists, first matching rule
// index returned for each classify item, table words loaded by write items.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  item     | item_valid / item_stall     | op, node_op, src_count, src0_op,
//           |                             | dtype_code, arg_int, arg_value,
//           |                             | rule_addr, word_sel, word_data
//  result   | result_valid / result_stall | matched, rule_index
//
//  A write passes the back sequencer's idle and result states, a classify idle,
//  count, scan (non-empty list) and result, scanning at most RULES_PER_OP rules,
//  plus one front stage. The scan reads one rule per cycle at the read address
//  shared by the rule memories. Reset clears the rule counts of every opcode;
//  rule words are undefined until written. A two-entry queue lets the front
//  keep taking items while the back scans or the result output is stalled.
// ----------------------------------------------------------------------------
module first_match_rule_classifier #(
	parameter int OP_CODES     = 128,
	parameter int RULES_PER_OP = 16,
	parameter int SET_SIZE     = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               op,
	input  logic [6:0]         node_op,
	input  logic [7:0]         src_count,
	input  logic [6:0]         src0_op,
	input  logic [7:0]         dtype_code,
	input  logic               arg_int,
	input  logic signed [63:0] arg_value,
	input  logic [10:0]        rule_addr,
	input  logic [1:0]         word_sel,
	input  logic [63:0]        word_data,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               matched,
	output logic [3:0]         rule_index
);
	import fmrc_pkg::*;

	logic      q_push;
	logic      q_pop;
	cmd_t      q_cmd;
	cmd_t      q_head;
	q_status_t q_stat;

	// front: accept and decode
	fmrc_front #(
		.OP_CODES     (OP_CODES),
		.RULES_PER_OP (RULES_PER_OP)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.op         (op),
		.node_op    (node_op),
		.src_count  (src_count),
		.src0_op    (src0_op),
		.dtype_code (dtype_code),
		.arg_int    (arg_int),
		.arg_value  (arg_value),
		.rule_addr  (rule_addr),
		.word_sel   (word_sel),
		.word_data  (word_data),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	// command queue
	fmrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	// back: table writes and rule scan
	fmrc_back #(
		.OP_CODES     (OP_CODES),
		.RULES_PER_OP (RULES_PER_OP),
		.SET_SIZE     (SET_SIZE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.matched      (matched),
		.rule_index   (rule_index)
	);

	// queue never takes a command while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("command queue overflow");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command queue underflow");

	// a reported rule lies inside the opcode list
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && matched |-> 32'(rule_index) < 32'(RULES_PER_OP))
		else $error("rule index beyond list length");

endmodule
